FILE: rtl/core/udiv_pkg.sv
// ----------------------------------------------------------------------------
// udiv_pkg
// Shared types and constants of the unsigned divider: operand width default,
// controller states and the command/status words between control and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package udiv_pkg;

  localparam int unsigned DataWidthDef = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } udiv_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture operands, clear partial remainder
    logic step;     // produce one quotient bit
    logic publish;  // move the finished result to the output register
  } udiv_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;     // this step yields the final quotient bit
  } udiv_status_t;

endpackage : udiv_pkg

`default_nettype wire

FILE: rtl/core/udiv_if.sv
// ----------------------------------------------------------------------------
// udiv_if
// Valid/ready channels of the divider: operand channel and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface udiv_in_if #(
  parameter int unsigned DataWidth = 64
);
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] dividend;
  logic [DataWidth-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface : udiv_in_if

interface udiv_out_if #(
  parameter int unsigned DataWidth = 64
);
  logic                 valid;
  logic                 ready;
  logic [DataWidth-1:0] quotient;
  logic [DataWidth-1:0] remainder;
  logic                 divide_by_zero;

  modport source (output valid, output quotient, output remainder, output divide_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input divide_by_zero,
                  output ready);
endinterface : udiv_out_if

`default_nettype wire

FILE: rtl/core/udiv_ctrl.sv
// ----------------------------------------------------------------------------
// udiv_ctrl
// Sequencer of the divider: takes a word, runs the bit steps, then hands the
// result to the output register once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire udiv_pkg::udiv_status_t status_i,
  output udiv_pkg::udiv_cmd_t         cmd_o
);
  import udiv_pkg::*;

  udiv_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.publish = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // hold the result valid until taken, reload on publish
  assign out_valid_d = cmd_o.publish || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule : udiv_ctrl

`default_nettype wire

FILE: rtl/core/udiv_datapath.sv
// ----------------------------------------------------------------------------
// udiv_datapath
// Restoring shift-subtract datapath: partial remainder, dividend/quotient
// shift register, divisor, bit counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module udiv_datapath #(
  parameter int unsigned DataWidth = udiv_pkg::DataWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire udiv_pkg::udiv_cmd_t    cmd_i,
  output udiv_pkg::udiv_status_t      status_o,
  input  wire logic [DataWidth-1:0]   dividend_i,
  input  wire logic [DataWidth-1:0]   divisor_i,
  output logic      [DataWidth-1:0]   quotient_o,
  output logic      [DataWidth-1:0]   remainder_o,
  output logic                        divide_by_zero_o
);
  import udiv_pkg::*;

  localparam int unsigned CntWidth = (DataWidth > 1) ? $clog2(DataWidth) : 1;
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(DataWidth - 1);

  logic [DataWidth-1:0] div_q;
  logic [DataWidth-1:0] quo_q, quo_d;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic                 dz_q;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic [DataWidth-1:0] quo_out_q;
  logic [DataWidth-1:0] rem_out_q;
  logic                 dz_out_q;

  logic [DataWidth:0]   rem_shift;
  logic [DataWidth:0]   diff;
  logic                 fits;

  // shift the next dividend bit into the remainder and trial-subtract
  assign rem_shift = {rem_q, quo_q[DataWidth-1]};
  assign diff      = rem_shift - {1'b0, div_q};
  assign fits      = !diff[DataWidth];

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = '0;
    end else if (cmd_i.step) begin
      quo_d = {quo_q[DataWidth-2:0], fits};
      rem_d = fits ? diff[DataWidth-1:0] : rem_shift[DataWidth-1:0];
      cnt_d = cnt_q + CntWidth'(1);
    end
  end

  assign status_o.last = cmd_i.step && (cnt_q == CntLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      div_q <= divisor_i;
      dz_q  <= (divisor_i == '0);
    end
    // a zero divisor reports zero quotient and remainder
    if (cmd_i.publish) begin
      quo_out_q <= dz_q ? '0 : quo_q;
      rem_out_q <= dz_q ? '0 : rem_q;
      dz_out_q  <= dz_q;
    end
  end

  assign quotient_o       = quo_out_q;
  assign remainder_o      = rem_out_q;
  assign divide_by_zero_o = dz_out_q;

endmodule : udiv_datapath

`default_nettype wire

FILE: rtl/core/unsigned_divide_64_unit.sv
// ----------------------------------------------------------------------------
// unsigned_divide_64_unit
// Unsigned integer divider giving quotient, remainder and a zero-divisor flag.
// ----------------------------------------------------------------------------
// Usage:
//   Operand words (dividend, divisor) enter on div_in_i; result words
//   (quotient, remainder, divide_by_zero) leave on div_out_o. Both are
//   valid/ready channels; a word moves when valid and ready are both high.
//   One word is divided at a time. After acceptance the datapath produces one
//   quotient bit per cycle in a single shift-subtract unit, then the result
//   moves into the output register; the next operand word is taken only
//   after that move.
//   The output register parts the two sides: the next word is accepted and
//   divided while a result still waits. If the receiver stalls longer, the
//   finished result holds in the datapath until the output register frees.
//   A zero divisor gives quotient 0, remainder 0 and divide_by_zero set.
//   Reset (rst_ni low, asynchronous) returns the sequencer to idle, drops
//   any pending result and clears the bit counter; other datapath registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_divide_64_unit #(
  parameter int unsigned DATA_WIDTH = udiv_pkg::DataWidthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  udiv_in_if.sink   div_in_i,
  udiv_out_if.source div_out_o
);
  import udiv_pkg::*;

  udiv_cmd_t    cmd;
  udiv_status_t status;

  udiv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_in_i.valid),
    .in_ready_o  (div_in_i.ready),
    .out_valid_o (div_out_o.valid),
    .out_ready_i (div_out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  udiv_datapath #(
    .DataWidth (DATA_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .dividend_i       (div_in_i.dividend),
    .divisor_i        (div_in_i.divisor),
    .quotient_o       (div_out_o.quotient),
    .remainder_o      (div_out_o.remainder),
    .divide_by_zero_o (div_out_o.divide_by_zero)
  );

endmodule : unsigned_divide_64_unit

`default_nettype wire

FILE: sim/unsigned_divide_64_unit_tb.sv
// ----------------------------------------------------------------------------
// unsigned_divide_64_unit_tb
// Self-checking bench for the 64-bit unsigned divider. Operand words go in
// over the valid/ready operand channel with streaming and bursty timing. Each accepted word
// pushes its expected quotient, remainder and zero-divisor flag. The result
// channel stalls on its own pattern, and every result word is checked
// against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unsigned_divide_64_unit_tb;

  import udiv_pkg::*;

  localparam int unsigned DATA_WIDTH  = 64;
  localparam int unsigned LATENCY     = DATA_WIDTH + 2;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
    logic  divide_by_zero;
  } div_result_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_HEAVY
  } rx_mode_e;

  typedef enum logic [2:0] {
    OPND_FULL,
    OPND_NARROW,
    OPND_SHARED_TZ,
    OPND_FITS_32,
    OPND_ZERO_DIVISOR,
    OPND_DIVISOR_ABOVE,
    OPND_TINY_DIVISOR
  } operand_kind_e;

  logic clk_i;
  logic rst_ni;

  udiv_in_if  #(.DataWidth(DATA_WIDTH)) div_in ();
  udiv_out_if #(.DataWidth(DATA_WIDTH)) div_out ();

  unsigned_divide_64_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .div_in_i (div_in),
    .div_out_o(div_out)
  );

  div_result_t expected_quot_rem_q[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;

  // sender pacing
  bit          tx_idle_en;
  int unsigned tx_burst_left;

  // receiver pacing
  rx_mode_e    rx_mode;
  bit          rx_hold_req;
  int unsigned rx_hold_left;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  initial begin
    div_out.ready = 1'b0;
  end

  // result side: long hold first, then the selected stall pattern
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      div_out.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: begin
          div_out.ready <= 1'b1;
        end
        RX_RANDOM: begin
          div_out.ready <= ($urandom_range(0, 99) >= 40);
        end
        default: begin
          // long dead stretches with short openings
          div_out.ready <= ($urandom_range(0, 99) >= 90);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // floor division; a zero divisor flags and returns zeros
  function automatic div_result_t compute_quotient(word_t dividend, word_t divisor);
    div_result_t res;
    res = '0;
    if (divisor == '0) begin
      res.divide_by_zero = 1'b1;
    end else begin
      res.quotient  = dividend / divisor;
      res.remainder = dividend % divisor;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    div_result_t exp_res;
    if (rst_ni && div_out.valid && div_out.ready) begin
      if (expected_quot_rem_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("[%0t] unexpected result word: q=%h r=%h dz=%b", $realtime,
                   div_out.quotient, div_out.remainder, div_out.divide_by_zero);
        end
      end else begin
        exp_res = expected_quot_rem_q.pop_front();
        if (div_out.quotient !== exp_res.quotient ||
            div_out.remainder !== exp_res.remainder ||
            div_out.divide_by_zero !== exp_res.divide_by_zero) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] result mismatch: exp q=%h r=%h dz=%b, got q=%h r=%h dz=%b",
                     $realtime, exp_res.quotient, exp_res.remainder,
                     exp_res.divide_by_zero, div_out.quotient, div_out.remainder,
                     div_out.divide_by_zero);
          end
        end
      end
    end
  end

  function automatic word_t random_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_division(input word_t dividend, input word_t divisor);
    int unsigned gap;
    div_in.valid    <= 1'b1;
    div_in.dividend <= dividend;
    div_in.divisor  <= divisor;
    do @(posedge clk_i); while (!div_in.ready);
    expected_quot_rem_q.push_back(compute_quotient(dividend, divisor));
    if (tx_idle_en) begin
      if (tx_burst_left == 0) begin
        // gaps up past one full divide so they land on every step
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 6);
        div_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
        tx_burst_left = $urandom_range(0, 12);
      end else begin
        tx_burst_left--;
      end
    end
  endtask

  task automatic send_random_division();
    operand_kind_e kind;
    word_t         dividend;
    word_t         divisor;
    word_t         swap_word;
    int unsigned   tz;
    int unsigned   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      kind = OPND_FULL;
    else if (pick < 52) kind = OPND_NARROW;
    else if (pick < 67) kind = OPND_SHARED_TZ;
    else if (pick < 79) kind = OPND_FITS_32;
    else if (pick < 84) kind = OPND_ZERO_DIVISOR;
    else if (pick < 94) kind = OPND_DIVISOR_ABOVE;
    else                kind = OPND_TINY_DIVISOR;
    dividend = random_word();
    divisor  = random_word();
    case (kind)
      OPND_NARROW: begin
        dividend = dividend >> $urandom_range(0, 63);
        divisor  = divisor >> $urandom_range(0, 63);
      end
      OPND_SHARED_TZ: begin
        tz       = $urandom_range(1, 63);
        dividend = (dividend >> $urandom_range(0, 63)) << tz;
        divisor  = (divisor >> $urandom_range(tz, 63)) << tz;
        if (divisor == '0) divisor = word_t'(1) << tz;
      end
      OPND_FITS_32: begin
        dividend = {32'h0, dividend[31:0]};
        divisor  = {32'h0, divisor[31:0] >> $urandom_range(0, 31)};
      end
      OPND_ZERO_DIVISOR: begin
        divisor = '0;
        if ($urandom_range(0, 3) == 0) dividend = '0;
      end
      OPND_DIVISOR_ABOVE: begin
        dividend = dividend >> $urandom_range(0, 40);
        if (divisor < dividend) begin
          swap_word = divisor;
          divisor   = dividend;
          dividend  = swap_word;
        end
      end
      OPND_TINY_DIVISOR: begin
        divisor = word_t'($urandom_range(1, 3));
        if ($urandom_range(0, 3) == 0) divisor = dividend;
      end
      default: begin
      end
    endcase
    send_division(dividend, divisor);
  endtask

  task automatic test_directed_corners();
    tx_idle_en = 1'b0;
    rx_mode    = RX_ALWAYS;
    send_division(64'h0, 64'h1);
    send_division(64'h0, 64'h0);
    send_division(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_division(64'hFFFF_FFFF_FFFF_FFFF, 64'h1);
    send_division(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_division(64'h1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_division(64'hFFFF_FFFF_FFFF_FFFF, 64'h2);
    send_division(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_division(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_division(64'h8000_0000_0000_0000, 64'h3);
    send_division(64'hFFFF_0000_0000_0000, 64'h0000_0000_0000_0100);
    send_division(64'h1234_5678_0000_0000, 64'h0000_0010_0000_0000);
    send_division(64'hFFFF_FFFF_0000_0000, 64'h0000_0001_0000_0000);
    send_division(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
    send_division(64'h0000_0000_8000_0000, 64'h1);
    send_division(64'h0000_0000_FFFF_FFFF, 64'h1);
    send_division(64'h0000_0000_FFFF_FFFF, 64'h0000_0000_8000_0000);
    send_division(64'h0000_0000_FFFF_FFFE, 64'h0000_0000_FFFF_FFFF);
    send_division(64'h5, 64'h7);
    send_division(64'h64, 64'h7);
    send_division(64'hA5A5_A5A5_5A5A_5A5A, 64'h5A5A_5A5A_A5A5_A5A5);
    send_division(64'h5A5A_5A5A_A5A5_A5A5, 64'h0000_0001_0000_0001);
  endtask

  task automatic test_random_streaming(input int unsigned count);
    tx_idle_en = 1'b0;
    rx_mode    = RX_ALWAYS;
    repeat (count) send_random_division();
  endtask

  task automatic test_random_bursty(input int unsigned count);
    tx_idle_en    = 1'b1;
    tx_burst_left = 0;
    rx_mode       = RX_RANDOM;
    repeat (count) send_random_division();
  endtask

  task automatic test_random_heavy_stall(input int unsigned count);
    tx_idle_en    = 1'b1;
    tx_burst_left = 0;
    rx_mode       = RX_HEAVY;
    repeat (count) send_random_division();
  endtask

  // block the result side for a long stretch while operands keep coming
  task automatic test_long_result_hold();
    tx_idle_en  = 1'b0;
    rx_mode     = RX_RANDOM;
    rx_hold_req = 1'b1;
    repeat (30) send_random_division();
  endtask

  initial begin
    mismatch_count  = 0;
    cycle_count     = 0;
    tx_idle_en      = 1'b0;
    tx_burst_left   = 0;
    rx_mode         = RX_ALWAYS;
    rx_hold_req     = 1'b0;
    rx_hold_left    = 0;
    rst_ni          = 1'b0;
    div_in.valid    = 1'b0;
    div_in.dividend = '0;
    div_in.divisor  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_streaming(200);
    test_random_bursty(500);
    test_long_result_hold();
    test_random_heavy_stall(250);
    test_random_bursty(250);

    div_in.valid <= 1'b0;
    while (expected_quot_rem_q.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule : unsigned_divide_64_unit_tb

`default_nettype wire

FILE: files.f
rtl/core/udiv_pkg.sv
rtl/core/udiv_if.sv
rtl/core/udiv_ctrl.sv
rtl/core/udiv_datapath.sv
rtl/core/unsigned_divide_64_unit.sv
sim/unsigned_divide_64_unit_tb.sv
